FILE: hdl/packed_int_dot_product_accumulate_unit_assert.svh
// Assertion macros for the packed integer dot product unit.
// Used by the top level; no other dependencies.
`ifndef PACKED_INT_DOT_PRODUCT_ACCUMULATE_UNIT_ASSERT_SVH
`define PACKED_INT_DOT_PRODUCT_ACCUMULATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PIDPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define PIDPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PIDPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define PIDPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/pidpa_pkg.sv
// Shared types and constants for the packed integer dot product unit.
// No dependencies.
package pidpa_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned FMT_WIDTH  = 2;

   localparam logic [FMT_WIDTH-1:0] FMT_S8 = 2'd0;
   localparam logic [FMT_WIDTH-1:0] FMT_U8 = 2'd1;
   localparam logic [FMT_WIDTH-1:0] FMT_S4 = 2'd2;
   localparam logic [FMT_WIDTH-1:0] FMT_U4 = 2'd3;

   localparam int unsigned LANES_8 = 4;
   localparam int unsigned LANES_4 = 8;
   localparam int unsigned SUM_WIDTH = 20;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] a_word;
      logic [WORD_WIDTH-1:0] b_word;
      logic [WORD_WIDTH-1:0] acc_start;
      logic                  first;
      logic                  last;
   } pidpa_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] dot_result;
   } pidpa_rsp_type;

endpackage

FILE: hdl/pidpa_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on pidpa_pkg.
interface pidpa_req_if;
   import pidpa_pkg::*;

   logic          valid;
   logic          ready;
   pidpa_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pidpa_rsp_if;
   import pidpa_pkg::*;

   logic          valid;
   logic          ready;
   pidpa_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/packed_int_dot_product_accumulate_unit.sv
// Packed int8/int4 dot product with 32-bit wrapping accumulate.
// Depends on pidpa_pkg, pidpa_if.sv and the assertion macro header.
//
//  channel   | direction | carries
//  ----------+-----------+----------------------------------------------
//  req_chan  | in        | a_word, b_word, acc_start, first, last
//  rsp_chan  | out       | dot_result, one item per item marked last
//  csr_*     | in        | lane_format write (csr_we, csr_wdata)
//
// One item per cycle while no last item waits on a stalled result; an item is
// held in the input register, then its lane products and the accumulate are
// formed combinationally into acc_ff, and a last item's result into out_data_ff.
// Synchronous reset clears the accumulator to zero and lane_format to signed 8-bit.
// A stalled result holds the input register only for an item marked last.
`include "packed_int_dot_product_accumulate_unit_assert.svh"

module packed_int_dot_product_accumulate_unit (
   input  logic                          clock,
   input  logic                          reset,
   pidpa_req_if.sink                     req_chan,
   pidpa_rsp_if.source                   rsp_chan,
   input  logic                          csr_we,
   input  logic [pidpa_pkg::FMT_WIDTH-1:0] csr_wdata
);
   import pidpa_pkg::*;

   logic [FMT_WIDTH-1:0]  lane_format_ff;
   logic                  s1_valid_ff;
   pidpa_req_type         s1_item_ff;
   logic [WORD_WIDTH-1:0] acc_ff;
   logic [WORD_WIDTH-1:0] acc_in;
   logic                  out_valid_ff;
   logic [WORD_WIDTH-1:0] out_data_ff;

   logic                  s1_fire;
   logic                  req_fire;
   logic                  lane_signed;
   logic                  lane_nibble;
   logic signed [SUM_WIDTH-1:0] sum_8;
   logic signed [SUM_WIDTH-1:0] sum_4;
   logic signed [SUM_WIDTH-1:0] prod_sum;
   logic [WORD_WIDTH-1:0] acc_base;

   assign s1_fire  = s1_valid_ff && (!s1_item_ff.last || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      unique case (lane_format_ff)
         FMT_S8: begin
            lane_signed = 1'b1;
            lane_nibble = 1'b0;
         end
         FMT_U8: begin
            lane_signed = 1'b0;
            lane_nibble = 1'b0;
         end
         FMT_S4: begin
            lane_signed = 1'b1;
            lane_nibble = 1'b1;
         end
         FMT_U4: begin
            lane_signed = 1'b0;
            lane_nibble = 1'b1;
         end
      endcase
   end

   always_comb begin
      logic signed [8:0]  xa8;
      logic signed [8:0]  xb8;
      logic signed [4:0]  xa4;
      logic signed [4:0]  xb4;
      logic signed [17:0] p8;
      logic signed [9:0]  p4;
      sum_8 = '0;
      sum_4 = '0;
      for (int i = 0; i < LANES_8; i++) begin
         xa8 = {lane_signed & s1_item_ff.a_word[8*i+7], s1_item_ff.a_word[8*i +: 8]};
         xb8 = {lane_signed & s1_item_ff.b_word[8*i+7], s1_item_ff.b_word[8*i +: 8]};
         p8 = xa8 * xb8;
         sum_8 = sum_8 + SUM_WIDTH'(p8);
      end
      for (int i = 0; i < LANES_4; i++) begin
         xa4 = {lane_signed & s1_item_ff.a_word[4*i+3], s1_item_ff.a_word[4*i +: 4]};
         xb4 = {lane_signed & s1_item_ff.b_word[4*i+3], s1_item_ff.b_word[4*i +: 4]};
         p4 = xa4 * xb4;
         sum_4 = sum_4 + SUM_WIDTH'(p4);
      end
   end

   assign prod_sum = lane_nibble ? sum_4 : sum_8;
   assign acc_base = s1_item_ff.first ? s1_item_ff.acc_start : acc_ff;
   assign acc_in   = acc_base + WORD_WIDTH'(prod_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_format_ff <= FMT_S8;
      end else if (csr_we) begin
         lane_format_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s1_fire) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && s1_item_ff.last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_item_ff.last) begin
         out_data_ff <= acc_in;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.payload.dot_result = out_data_ff;

   `PIDPA_ASSERT_NEXT(a_last_emits, clock, reset, s1_fire && s1_item_ff.last,
      rsp_chan.valid && (rsp_chan.payload.dot_result == acc_ff),
      "last item did not produce its result")
   `PIDPA_ASSERT_SAME(a_empty_ready, clock, reset, !s1_valid_ff, req_chan.ready,
      "empty input register refused an item")
   `PIDPA_ASSERT_NEXT(a_acc_hold, clock, reset, !s1_fire, $stable(acc_ff),
      "accumulator moved without an item")
   `PIDPA_ASSERT_SAME(a_no_overrun, clock, reset,
      out_valid_ff && !rsp_chan.ready && s1_item_ff.last, !s1_fire,
      "result overwritten while stalled")

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the packed integer dot product accumulate unit: random and directed
// items against a built-in predictor, with idle and stall phases on both channels.
// Depends on pidpa_pkg, the channel interfaces in pidpa_if.sv and the unit itself.
`timescale 1ns / 1ps

module tb_top;
   import pidpa_pkg::*;

   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [FMT_WIDTH-1:0] csr_wdata = FMT_S8;

   pidpa_req_if req_chan ();
   pidpa_rsp_if rsp_chan ();

   packed_int_dot_product_accumulate_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pidpa_req_type         req_backlog[$];
   logic [WORD_WIDTH-1:0] pending_dot_results[$];

   logic [FMT_WIDTH-1:0]  lane_fmt_model = FMT_S8;
   logic [WORD_WIDTH-1:0] acc_model = '0;
   int  queued_count = 0;
   int  accepted_count = 0;
   int  fail_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  req_taken = 1'b0;
   bit  hold_on = 1'b0;
   bit  pressure_go = 1'b0;

   always #2 clock = ~clock;

   // sum of lane products of one word pair, wrapped to 32 bits
   function automatic logic [WORD_WIDTH-1:0] word_dot(input logic [WORD_WIDTH-1:0] a,
                                                      input logic [WORD_WIDTH-1:0] b,
                                                      input logic [FMT_WIDTH-1:0] fmt);
      logic [WORD_WIDTH-1:0] sum;
      logic [WORD_WIDTH-1:0] x;
      logic [WORD_WIDTH-1:0] y;
      bit lane_signed;
      sum = '0;
      lane_signed = (fmt == FMT_S8) || (fmt == FMT_S4);
      if (fmt == FMT_S4 || fmt == FMT_U4) begin
         for (int i = 0; i < LANES_4; i++) begin
            x = {28'b0, a[i*4 +: 4]};
            y = {28'b0, b[i*4 +: 4]};
            if (lane_signed && x[3]) x[31:4] = '1;
            if (lane_signed && y[3]) y[31:4] = '1;
            sum = sum + x * y;
         end
      end else begin
         for (int i = 0; i < LANES_8; i++) begin
            x = {24'b0, a[i*8 +: 8]};
            y = {24'b0, b[i*8 +: 8]};
            if (lane_signed && x[7]) x[31:8] = '1;
            if (lane_signed && y[7]) y[31:8] = '1;
            sum = sum + x * y;
         end
      end
      return sum;
   endfunction

   function automatic pidpa_req_type noise_item();
      pidpa_req_type it;
      it.a_word    = $urandom;
      it.b_word    = $urandom;
      it.acc_start = $urandom;
      it.first     = 1'($urandom_range(1));
      it.last      = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      logic [WORD_WIDTH-1:0] corners[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080,
                                             32'h7F7F_7F7F, 32'h8888_8888, 32'h7777_7777,
                                             32'h0101_0101, 32'h1111_1111};
      if ($urandom_range(7) == 0) return corners[3'($urandom_range(7))];
      return $urandom;
   endfunction

   // driver: hold the offered item until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= req_backlog.pop_front();
         end else begin
            req_chan.valid   <= 1'b0;
            req_chan.payload <= noise_item();
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && !hold_on && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: check the result channel, then predict from the item taken this edge
   always @(posedge clock) begin
      logic [WORD_WIDTH-1:0] want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_dot_results.size() == 0) begin
               $display("%0t: unexpected dot_result, expected none, got %h",
                        $time, rsp_chan.payload.dot_result);
               fail_count++;
            end else begin
               want = pending_dot_results.pop_front();
               if (rsp_chan.payload.dot_result !== want) begin
                  $display("%0t: dot_result mismatch, expected %h, got %h",
                           $time, want, rsp_chan.payload.dot_result);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            accepted_count <= accepted_count + 1;
            if (req_chan.payload.first) acc_model = req_chan.payload.acc_start;
            acc_model = acc_model + word_dot(req_chan.payload.a_word, req_chan.payload.b_word,
                                             lane_fmt_model);
            if (req_chan.payload.last) pending_dot_results = {pending_dot_results, acc_model};
         end
      end
   end

   // long receiver hold while the sender keeps offering items
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   task automatic queue_item(input logic [WORD_WIDTH-1:0] a, input logic [WORD_WIDTH-1:0] b,
                             input logic [WORD_WIDTH-1:0] start, input bit first,
                             input bit last);
      pidpa_req_type it;
      it.a_word    = a;
      it.b_word    = b;
      it.acc_start = start;
      it.first     = first;
      it.last      = last;
      req_backlog = {req_backlog, it};
      queued_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_count != queued_count || pending_dot_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_lane_fmt(input logic [FMT_WIDTH-1:0] fmt);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= fmt;
      @(posedge clock);
      lane_fmt_model = fmt;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random_items(input int n, input int max_len);
      int target;
      int len;
      target = queued_count + n;
      while (queued_count < target) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(max_len, 1);
            for (int k = 0; k < len; k++)
               queue_item(pick_word(), pick_word(), $urandom, k == 0, k == len - 1);
         end else begin
            queue_item($urandom, $urandom, $urandom, 1'($urandom_range(1)),
                       1'($urandom_range(1)));
         end
      end
   endtask

   task automatic run_phase(input logic [FMT_WIDTH-1:0] fmt, input int n,
                            input int send_pct, input int stall_pct);
      write_lane_fmt(fmt);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      queue_random_items(n, 8);
      wait_drained();
   endtask

   initial begin
      logic [FMT_WIDTH-1:0] fmts[3];
      fmts = '{FMT_U8, FMT_S4, FMT_U4};
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format, no first since reset, accumulate across last, first with last
      queue_item(32'h7F7F_7F7F, 32'h8080_8080, 32'h1234_5678, 1'b0, 1'b0);
      queue_item(32'h8080_8080, 32'h8080_8080, 32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_item(32'hFFFF_FFFF, 32'h0101_0101, 32'h0000_0000, 1'b0, 1'b1);
      queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_item(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
      queue_item(32'h7F80_FF01, 32'h807F_01FF, 32'h0000_0000, 1'b0, 1'b1);
      wait_drained();

      foreach (fmts[f]) begin
         write_lane_fmt(fmts[f]);
         queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
         queue_item(32'h8888_8888, 32'h7777_7777, 32'h0000_0000, 1'b0, 1'b1);
         queue_item(32'h8080_8080, 32'h8888_8888, 32'hFFFF_FFF0, 1'b1, 1'b1);
         queue_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0, 1'b1);
         wait_drained();
      end

      run_phase(FMT_S8, 60, 0, 0);
      run_phase(FMT_U8, 60, 75, 0);
      run_phase(FMT_S4, 60, 0, 75);
      run_phase(FMT_U4, 60, 23, 23);
      run_phase(FMT_U4, 60, 0, 0);
      run_phase(FMT_S4, 60, 75, 0);
      run_phase(FMT_U8, 60, 0, 75);
      run_phase(FMT_S8, 60, 23, 23);

      // short sequences under a long receiver hold so the unit backs up
      write_lane_fmt(FMT_S8);
      @(posedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random_items(40, 2);
      pressure_go = 1'b1;
      wait_drained();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/pidpa_pkg.sv
hdl/pidpa_if.sv
hdl/packed_int_dot_product_accumulate_unit.sv
tb/sv/tb_top.sv
